### rtl/gbf_pkg.sv
// ----------------------------------------------------------------------------
// gbf_pkg
// Shared types, register indexes and the GF(2^8) bit-matrix product used by
// the additive FFT butterfly pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gbf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned Lanes   = 4;
  localparam int unsigned MatW    = 64;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [2:0] {
    MODE_FFT4      = 3'd0,
    MODE_IFFT4     = 3'd1,
    MODE_IFFT4_XOR = 3'd2,
    MODE_IFFT2     = 3'd3,
    MODE_IFFT2_XOR = 3'd4,
    MODE_MUL       = 3'd5,
    MODE_MULADD    = 3'd6
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE = 2'd0,
    CFG_TOP  = 2'd1,
    CFG_LOW  = 2'd2,
    CFG_HIGH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    mode_e             mode;
    logic [MatW-1:0]   top;
    logic [MatW-1:0]   low;
    logic [MatW-1:0]   high;
  } cfg_t;

  // one byte position moving down the pipe
  typedef struct packed {
    logic                         last;
    logic [Lanes-1:0][ByteW-1:0]  acc;
    logic [Lanes-1:0][ByteW-1:0]  x;
  } beat_t;

  // result bit i is the parity of matrix byte 7-i masked with the data
  function automatic logic [ByteW-1:0] aff_mul(input logic [MatW-1:0] m,
                                               input logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    r = '0;
    for (int i = 0; i < ByteW; i++) begin
      r[i] = ^(m[ByteW*(ByteW-1-i) +: ByteW] & v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/gbf_stage1.sv
// ----------------------------------------------------------------------------
// gbf_stage1
// First pipe stage: top twiddle products of the forward butterfly and the
// leading sums of the inverse butterflies.
// ----------------------------------------------------------------------------
`default_nettype none

module gbf_stage1
  import gbf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  beat_t beat_i,
  output logic  valid_o,
  input  logic  ready_i,
  output beat_t beat_o
);

  logic  valid_q, valid_d;
  beat_t beat_q, beat_d;
  logic [ByteW-1:0] a, b, c, d;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    a = beat_i.x[0];
    b = beat_i.x[1];
    c = beat_i.x[2];
    d = beat_i.x[3];
    case (cfg_i.mode) inside
      MODE_FFT4: begin
        a = beat_i.x[0] ^ aff_mul(cfg_i.top, beat_i.x[2]);
        b = beat_i.x[1] ^ aff_mul(cfg_i.top, beat_i.x[3]);
        c = beat_i.x[2] ^ a;
        d = beat_i.x[3] ^ b;
      end
      MODE_IFFT4, MODE_IFFT4_XOR: begin
        b = beat_i.x[1] ^ beat_i.x[0];
        d = beat_i.x[3] ^ beat_i.x[2];
      end
      MODE_IFFT2, MODE_IFFT2_XOR: begin
        b = beat_i.x[1] ^ beat_i.x[0];
      end
      default: begin
      end
    endcase
    beat_d      = beat_i;
    beat_d.x[0] = a;
    beat_d.x[1] = b;
    beat_d.x[2] = c;
    beat_d.x[3] = d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

### rtl/gbf_stage2.sv
// ----------------------------------------------------------------------------
// gbf_stage2
// Second pipe stage: low and high twiddle products of the four-point butterflies;
// the two-point and multiply modes use the low product alone.
`default_nettype none

module gbf_stage2
  import gbf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  beat_t beat_i,
  output logic  valid_o,
  input  logic  ready_i,
  output beat_t beat_o
);

  logic  valid_q, valid_d;
  beat_t beat_q, beat_d;
  logic [ByteW-1:0] a, b, c, d;
  logic [ByteW-1:0] lo_p, hi_p;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  assign lo_p = aff_mul(cfg_i.low, beat_i.x[1]);
  assign hi_p = aff_mul(cfg_i.high, beat_i.x[3]);

  always_comb begin
    a = beat_i.x[0];
    b = beat_i.x[1];
    c = beat_i.x[2];
    d = beat_i.x[3];
    case (cfg_i.mode) inside
      MODE_FFT4: begin
        a = beat_i.x[0] ^ lo_p;
        c = beat_i.x[2] ^ hi_p;
      end
      MODE_IFFT4, MODE_IFFT4_XOR: begin
        a = beat_i.x[0] ^ lo_p;
        c = beat_i.x[2] ^ hi_p ^ a;
        d = beat_i.x[3] ^ beat_i.x[1];
      end
      MODE_IFFT2, MODE_IFFT2_XOR: begin
        a = beat_i.x[0] ^ lo_p;
      end
      MODE_MUL, MODE_MULADD: begin
        // single coefficient applies to the source byte
        a = aff_mul(cfg_i.low, beat_i.x[0]);
      end
      default: begin
      end
    endcase
    beat_d      = beat_i;
    beat_d.x[0] = a;
    beat_d.x[1] = b;
    beat_d.x[2] = c;
    beat_d.x[3] = d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

### rtl/gbf_stage3.sv
// ----------------------------------------------------------------------------
// gbf_stage3
// Last pipe stage: closing sums of the forward butterfly, top twiddle of the
// inverse butterfly, accumulation, unused-byte clearing; its register is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbf_stage3
  import gbf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  beat_t beat_i,
  output logic  valid_o,
  input  logic  ready_i,
  output beat_t beat_o
);

  logic  valid_q, valid_d;
  beat_t beat_q, beat_d;
  logic [Lanes-1:0][ByteW-1:0] o;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    o = '0;
    case (cfg_i.mode) inside
      MODE_FFT4: begin
        o[0] = beat_i.x[0];
        o[1] = beat_i.x[1] ^ beat_i.x[0];
        o[2] = beat_i.x[2];
        o[3] = beat_i.x[3] ^ beat_i.x[2];
      end
      MODE_IFFT4, MODE_IFFT4_XOR: begin
        o[0] = beat_i.x[0] ^ aff_mul(cfg_i.top, beat_i.x[2]);
        o[1] = beat_i.x[1] ^ aff_mul(cfg_i.top, beat_i.x[3]);
        o[2] = beat_i.x[2];
        o[3] = beat_i.x[3];
        if (cfg_i.mode == MODE_IFFT4_XOR) begin
          o = o ^ beat_i.acc;
        end
      end
      MODE_IFFT2, MODE_IFFT2_XOR: begin
        o[0] = beat_i.x[0];
        o[1] = beat_i.x[1];
        if (cfg_i.mode == MODE_IFFT2_XOR) begin
          o[0] = beat_i.x[0] ^ beat_i.acc[0];
          o[1] = beat_i.x[1] ^ beat_i.acc[1];
        end
      end
      MODE_MUL: begin
        o[0] = beat_i.x[0];
      end
      MODE_MULADD: begin
        o[0] = beat_i.x[0] ^ beat_i.acc[0];
      end
      default: begin
        // undefined mode yields all-zero bytes
        o = '0;
      end
    endcase
    beat_d   = beat_i;
    beat_d.x = o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

### rtl/gf256_additive_fft_butterfly_top.sv
// a request passes the stage1, stage2 and stage3 registers in turn to the output
// throughput: one byte position per cycle while the output is not stalled; ready
// passes back through all stages at once; an output stall holds every full stage;
// bubbles still fill, so the input stops only once all three stages hold requests
// reset clears the stage valid bits and all four configuration registers
// ----------------------------------------------------------------------------
// gf256_additive_fft_butterfly_top
// GF(2^8) additive FFT butterfly, three-stage pipeline with a register
// write port for mode and twiddle bit matrices.
// ----------------------------------------------------------------------------
`default_nettype none

module gf256_additive_fft_butterfly_top
  import gbf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [MatW-1:0]      cfg_wdata_i,
  // input requests
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // in0, in1, in2, in3, acc0, acc1, acc2, acc3 from bit 0 up
  input  logic [2*Lanes*ByteW-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,
  // results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out0, out1, out2, out3 from bit 0 up
  output logic [Lanes*ByteW-1:0] m_axis_tdata,
  output logic                 m_axis_tlast
);

  logic [2:0]      mode_q;
  logic [MatW-1:0] top_q, low_q, high_q;
  cfg_t            cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      top_q  <= '0;
      low_q  <= '0;
      high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE: mode_q <= cfg_wdata_i[2:0];
        CFG_TOP:  top_q  <= cfg_wdata_i;
        CFG_LOW:  low_q  <= cfg_wdata_i;
        CFG_HIGH: high_q <= cfg_wdata_i;
        default:  mode_q <= mode_q;
      endcase
    end
  end

  assign cfg.mode = mode_e'(mode_q);
  assign cfg.top  = top_q;
  assign cfg.low  = low_q;
  assign cfg.high = high_q;

  beat_t in_beat, s1_beat, s2_beat, s3_beat;
  logic  s1_valid, s2_valid;
  logic  s2_ready, s3_ready;

  assign in_beat.x    = s_axis_tdata[Lanes*ByteW-1:0];
  assign in_beat.acc  = s_axis_tdata[2*Lanes*ByteW-1:Lanes*ByteW];
  assign in_beat.last = s_axis_tlast;

  gbf_stage1 u_stage1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .beat_i  (in_beat),
    .valid_o (s1_valid),
    .ready_i (s2_ready),
    .beat_o  (s1_beat)
  );

  gbf_stage2 u_stage2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .beat_i  (s1_beat),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .beat_o  (s2_beat)
  );

  gbf_stage3 u_stage3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .beat_i  (s2_beat),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .beat_o  (s3_beat)
  );

  assign m_axis_tdata = s3_beat.x;
  assign m_axis_tlast = s3_beat.last;

endmodule

`default_nettype wire

### rtl/gbf_checker.sv
// ----------------------------------------------------------------------------
// gbf_checker
// Port-level checks for the butterfly pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gbf_checker
  import gbf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [Lanes*ByteW-1:0]   m_axis_tdata,
  input  logic                     m_axis_tlast
);

  // nothing comes out right after reset
  a_no_out_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a draining sink never blocks new requests
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output is drained");

  // with the sink ready while it moves down the pipe, an accepted request shows up at the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      |=> m_axis_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind gf256_additive_fft_butterfly_top gbf_checker u_gbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### tb/gf256_butterfly_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf256_butterfly_check
// Follows the register port and both streams of the butterfly. Each accepted
// request is turned into its result bytes from the current mode and twiddle
// matrices, and the results are compared in order, byte by byte.
// ----------------------------------------------------------------------------
module gf256_butterfly_check
  import gbf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [MatW-1:0]          cfg_wdata_i,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  // in0, in1, in2, in3, acc0, acc1, acc2, acc3 from bit 0 up
  input  logic [2*Lanes*ByteW-1:0] s_axis_tdata,
  input  logic                     s_axis_tlast,
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // out0, out1, out2, out3 from bit 0 up
  input  logic [Lanes*ByteW-1:0]   m_axis_tdata,
  input  logic                     m_axis_tlast,
  output int                       fail_cnt_o,
  output int                       pending_o,
  output int                       checked_o
);

  typedef struct packed {
    logic            last;
    logic [3:0][7:0] bytes;
  } bfly_res_t;

  logic [2:0]  mode_q;
  logic [63:0] top_q;
  logic [63:0] low_q;
  logic [63:0] high_q;

  bfly_res_t predicted_outs[$];

  // row k of the matrix gives product bit 7-k
  function automatic logic [7:0] mat_apply(input logic [63:0] mat, input logic [7:0] v);
    logic [7:0] prod;
    for (int row = 0; row < 8; row++) begin
      prod[7-row] = ^(mat[8*row +: 8] & v);
    end
    return prod;
  endfunction

  function automatic bfly_res_t butterfly_outs(input logic [63:0] req, input logic last);
    logic [3:0][7:0] x;
    logic [3:0][7:0] acc;
    logic [3:0][7:0] o;
    logic [7:0]      a;
    logic [7:0]      b;
    logic [7:0]      c;
    logic [7:0]      d;
    bfly_res_t       r;
    x   = req[31:0];
    acc = req[63:32];
    o   = '0;
    case (mode_q)
      MODE_FFT4: begin
        a = x[0] ^ mat_apply(top_q, x[2]);
        b = x[1] ^ mat_apply(top_q, x[3]);
        c = x[2] ^ a;
        d = x[3] ^ b;
        a = a ^ mat_apply(low_q, b);
        b = b ^ a;
        c = c ^ mat_apply(high_q, d);
        d = d ^ c;
        o = {d, c, b, a};
      end
      MODE_IFFT4, MODE_IFFT4_XOR: begin
        b = x[1] ^ x[0];
        a = x[0] ^ mat_apply(low_q, b);
        d = x[3] ^ x[2];
        c = x[2] ^ mat_apply(high_q, d);
        c = c ^ a;
        d = d ^ b;
        a = a ^ mat_apply(top_q, c);
        b = b ^ mat_apply(top_q, d);
        o = {d, c, b, a};
        if (mode_q == MODE_IFFT4_XOR) begin
          o = o ^ acc;
        end
      end
      MODE_IFFT2, MODE_IFFT2_XOR: begin
        b = x[1] ^ x[0];
        a = x[0] ^ mat_apply(low_q, b);
        if (mode_q == MODE_IFFT2_XOR) begin
          a = a ^ acc[0];
          b = b ^ acc[1];
        end
        o[0] = a;
        o[1] = b;
      end
      MODE_MUL: begin
        o[0] = mat_apply(low_q, x[0]);
      end
      MODE_MULADD: begin
        o[0] = acc[0] ^ mat_apply(low_q, x[0]);
      end
      default: begin
        o = '0;
      end
    endcase
    r.bytes = o;
    r.last  = last;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: result %0d %s: got %h, want %h", $time, checked_o, what, got, want);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bfly_res_t want;
    if (!rst_ni) begin
      mode_q    <= MODE_FFT4;
      top_q     <= '0;
      low_q     <= '0;
      high_q    <= '0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE: mode_q <= cfg_wdata_i[2:0];
          CFG_TOP:  top_q  <= cfg_wdata_i;
          CFG_LOW:  low_q  <= cfg_wdata_i;
          CFG_HIGH: high_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_outs.push_back(butterfly_outs(s_axis_tdata, s_axis_tlast));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_outs.size() == 0) begin
          report_mismatch("arrived with no request pending", m_axis_tdata, '0);
        end else begin
          want = predicted_outs.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (m_axis_tdata[8*k +: 8] !== want.bytes[k]) begin
              report_mismatch($sformatf("out%0d", k), 32'(m_axis_tdata[8*k +: 8]),
                              32'(want.bytes[k]));
            end
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
          end
          checked_o++;
        end
      end
      pending_o <= predicted_outs.size();
    end
  end

endmodule

### tb/gf256_additive_fft_butterfly_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf256_additive_fft_butterfly_top_test
// Drives register settings and byte-position requests into the butterfly
// pipeline under bursty input and a stalling output, and takes the verdict
// from the checker that sits beside it.
// ----------------------------------------------------------------------------
module gf256_additive_fft_butterfly_top_test;
  import gbf_pkg::*;

  localparam logic [2:0]  MODE_UNDEF  = 3'd7;
  localparam logic [63:0] IDENT_MAT   = 64'h0102_0408_1020_4080;
  localparam logic [63:0] ONES_MAT    = '1;
  localparam int          ITEMS       = 2000;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          HOLD_CYCLES = 64;
  localparam logic [7:0][2:0] MODE_SEQ = {MODE_UNDEF, MODE_MULADD, MODE_MUL, MODE_IFFT2_XOR,
                                          MODE_IFFT2, MODE_IFFT4_XOR, MODE_IFFT4, MODE_FFT4};

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i     = '0;
  logic [MatW-1:0]          cfg_wdata_i   = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic [2*Lanes*ByteW-1:0] s_axis_tdata  = '0;
  logic                     s_axis_tlast  = 1'b0;
  logic                     m_axis_tready = 1'b0;
  logic                     s_axis_tready;
  logic                     m_axis_tvalid;
  logic [Lanes*ByteW-1:0]   m_axis_tdata;
  logic                     m_axis_tlast;

  int         fail_cnt;
  int         pending;
  int         checked;
  int         sent        = 0;
  int         phases      = 0;
  int         cycles      = 0;
  int         burst_left  = 0;
  logic       steady      = 1'b0;
  int         hold_reqs   = 0;
  int         hold_seen   = 0;
  int         hold_left   = 0;
  logic [15:0] rdy_pattern = '1;
  int         rdy_phase   = 0;
  bit [7:0]   modes_seen  = '0;

  gf256_additive_fft_butterfly_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  gf256_butterfly_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results pending", cycles, pending);
      $display("gf256_additive_fft_butterfly_top: mismatch");
      $finish;
    end
  end

  // result side: a long hold-off on request, always ready in steady phases, otherwise a rotating stall mask
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen     <= hold_reqs;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= rdy_pattern[rdy_phase];
      if (rdy_phase == 15) begin
        rdy_phase <= 0;
        case ($urandom_range(0, 3))
          0: rdy_pattern <= '1;
          1: rdy_pattern <= 16'($urandom_range(0, 65535) | 32'h0001);
          2: rdy_pattern <= 16'(($urandom_range(0, 65535) & $urandom_range(0, 65535))
                                | 32'h0001);
          default: rdy_pattern <= 16'($urandom_range(0, 65535) | $urandom_range(0, 65535));
        endcase
      end else begin
        rdy_phase <= rdy_phase + 1;
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] rand_req();
    logic [63:0] r;
    for (int k = 0; k < 8; k++) begin
      r[8*k +: 8] = rand_byte();
    end
    return r;
  endfunction

  function automatic logic [63:0] rand_matrix();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ONES_MAT;
      2: return IDENT_MAT;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // request side: bursts of random length, gaps only at burst starts
  task automatic send_req(input logic [63:0] data, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic cfg_put(input cfg_idx_e idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [2:0] md, input logic [63:0] tm,
                           input logic [63:0] lm, input logic [63:0] hm);
    wait_drained();
    cfg_put(CFG_MODE, {61'b0, md});
    cfg_put(CFG_TOP, tm);
    cfg_put(CFG_LOW, lm);
    cfg_put(CFG_HIGH, hm);
    cfg_we_i <= 1'b0;
    modes_seen[md] = 1'b1;
    phases++;
  endtask

  initial begin
    logic [2:0] md;
    int         n;
    int         rnd_phase;
    logic       hold_phase;
    rnd_phase = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: forward butterfly with every twiddle zero
    modes_seen[MODE_FFT4] = 1'b1;
    phases = 1;
    send_req('0, 1'b0);
    send_req('1, 1'b1);
    send_req(64'h5aa5_3cc3_0ff0_a55a, 1'b0);

    // each mode code once, the undefined one included
    for (int k = 0; k < 8; k++) begin
      configure(MODE_SEQ[k], ONES_MAT, IDENT_MAT, rand_matrix());
      send_req('1, 1'b1);
      send_req(rand_req(), 1'b0);
    end

    while (sent < ITEMS) begin
      hold_phase = (rnd_phase == 1);
      steady <= hold_phase || ($urandom_range(0, 5) == 0);
      md = ($urandom_range(0, 15) == 0) ? MODE_UNDEF : MODE_SEQ[$urandom_range(0, 6)];
      configure(md, rand_matrix(), rand_matrix(), rand_matrix());
      n = hold_phase ? 200 : $urandom_range(20, 150);
      for (int i = 0; i < n; i++) begin
        // stall the result side long enough to back the pipe up to the input
        if (hold_phase && i == 8) begin
          hold_reqs <= hold_reqs + 1;
        end
        send_req(rand_req(), $urandom_range(0, 7) == 0);
      end
      rnd_phase++;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("%0d requests over %0d register settings, %0d of 8 mode codes used",
             sent, phases, $countones(modes_seen));
    $display("%0d results compared, %0d mismatching fields", checked, fail_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("gf256_additive_fft_butterfly_top: match");
    end else begin
      $display("gf256_additive_fft_butterfly_top: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/gbf_pkg.sv
rtl/gbf_stage1.sv
rtl/gbf_stage2.sv
rtl/gbf_stage3.sv
rtl/gf256_additive_fft_butterfly_top.sv
rtl/gbf_checker.sv
tb/gf256_butterfly_check.sv
tb/gf256_additive_fft_butterfly_top_test.sv
